// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the tracker's top level to check its behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that, when seen, implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hst_pkg.sv =====
// Types, codes and constants shared by the session tracker modules.
`timescale 1ns / 1ps

package hst_pkg;

    localparam int MAX_SESSIONS_DEF = 32;

    localparam logic [1:0] STAGE_OPEN   = 2'd1;
    localparam logic [1:0] STAGE_SYNACK = 2'd2;
    localparam logic [1:0] STAGE_DONE   = 2'd3;

    localparam logic [1:0] CLOSE_NONE = 2'd0;
    localparam logic [1:0] CLOSE_INIT = 2'd1;
    localparam logic [1:0] CLOSE_RESP = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_OPENED   = 3'd1,
        EV_SYNACK   = 3'd2,
        EV_DONE     = 3'd3,
        EV_FIN_INIT = 3'd4,
        EV_FIN_RESP = 3'd5,
        EV_FULL     = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        K_OPEN,
        K_SYNACK,
        K_ACK,
        K_FIN,
        K_OTHER
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  tcp_flags;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_value;
        logic [31:0] ack_value;
    } seg_t;

    typedef struct packed {
        logic [2:0]  event_code;
        logic [4:0]  entry_index;
        logic [15:0] handshakes_done;
        logic [5:0]  sessions_open;
        logic [5:0]  unfinished_count;
        logic [5:0]  irregular_close_count;
    } res_t;

    typedef struct packed {
        logic [15:0] init_port;
        logic [15:0] resp_port;
        logic [31:0] seq;
        logic [31:0] peer_seq;
        logic [1:0]  stage;
        logic [1:0]  close_mark;
    } entry_t;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic commit;
        logic finish_none;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  more;
        logic  hit;
    } dp_status_t;

endpackage

// ===== hw/rtl/hst_if.sv =====
// Request channels of the session tracker: segment headers in, results out.
`timescale 1ns / 1ps

interface hst_seg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tcp_flags;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_value;
    logic [31:0] ack_value;

    modport source (
        output valid, tcp_flags, source_port, dest_port, seq_value, ack_value,
        input  ready
    );
    modport sink (
        input  valid, tcp_flags, source_port, dest_port, seq_value, ack_value,
        output ready
    );
endinterface

interface hst_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic [4:0]  entry_index;
    logic [15:0] handshakes_done;
    logic [5:0]  sessions_open;
    logic [5:0]  unfinished_count;
    logic [5:0]  irregular_close_count;

    modport source (
        output valid, event_code, entry_index, handshakes_done, sessions_open,
               unfinished_count, irregular_close_count,
        input  ready
    );
    modport sink (
        input  valid, event_code, entry_index, handshakes_done, sessions_open,
               unfinished_count, irregular_close_count,
        output ready
    );
endinterface

// ===== hw/rtl/hst_ctrl.sv =====
// Controller state machine sequencing decode, table scan, update and result.
`timescale 1ns / 1ps

module hst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  hst_pkg::dp_status_t  status,
    output hst_pkg::dp_cmd_t     cmd
);

    hst_pkg::state_t state_reg;
    hst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hst_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hst_pkg::S_DECODE;
                end
            end
            hst_pkg::S_DECODE:
            begin
                if (status.kind == hst_pkg::K_OPEN)
                begin
                    state_next = status.full ? hst_pkg::S_OUT : hst_pkg::S_WRITE;
                end
                else if (status.kind == hst_pkg::K_OTHER || status.empty)
                begin
                    state_next = hst_pkg::S_OUT;
                end
                else
                begin
                    state_next = hst_pkg::S_SCAN;
                end
            end
            hst_pkg::S_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = hst_pkg::S_WRITE;
                end
                else if (!status.more)
                begin
                    state_next = hst_pkg::S_OUT;
                end
            end
            hst_pkg::S_WRITE:
            begin
                state_next = hst_pkg::S_OUT;
            end
            hst_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = hst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            hst_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            hst_pkg::S_DECODE:
            begin
                if (status.kind == hst_pkg::K_OPEN)
                begin
                    cmd.finish_none = status.full;
                end
                else if (status.kind == hst_pkg::K_OTHER || status.empty)
                begin
                    cmd.finish_none = 1'b1;
                end
                else
                begin
                    cmd.start = 1'b1;
                end
            end
            hst_pkg::S_SCAN:
            begin
                cmd.issue       = !status.hit && status.more;
                cmd.finish_none = !status.hit && !status.more;
            end
            hst_pkg::S_WRITE:
            begin
                cmd.commit = 1'b1;
            end
            hst_pkg::S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/hst_dp.sv =====
// Datapath: session table memory, entry compare, counters and result register.
`timescale 1ns / 1ps

module hst_dp #(
    parameter int MAX_SESSIONS = hst_pkg::MAX_SESSIONS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hst_pkg::seg_t        seg_in,
    input  hst_pkg::dp_cmd_t     cmd,
    output hst_pkg::dp_status_t  status,
    output hst_pkg::res_t        res
);

    localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
    localparam int CW = $clog2(MAX_SESSIONS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_SESSIONS);

    hst_pkg::entry_t mem [MAX_SESSIONS];

    hst_pkg::seg_t   seg_reg;
    hst_pkg::entry_t rdata_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic [CW-1:0]   rd_addr_reg;
    logic            rd_pend_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   unf_reg;
    logic [CW-1:0]   unf_next;
    logic [CW-1:0]   irr_reg;
    logic [CW-1:0]   irr_next;
    logic [15:0]     hs_reg;
    logic [15:0]     hs_next;
    hst_pkg::res_t   res_reg;

    hst_pkg::kind_t  kind;
    logic            same_dir;
    logic            rev_dir;
    logic            kind_hit;
    logic [31:0]     seq_inc;

    logic            we;
    logic [AW-1:0]   waddr;
    hst_pkg::entry_t wdata;
    hst_pkg::event_t ev;
    logic [AW-1:0]   idx;
    logic [AW+4:0]   idx_wide;

    function automatic logic [5:0] sat6(input logic [CW-1:0] v);
        logic [CW+5:0] w;
        w = (CW+6)'(v);
        sat6 = (w > (CW+6)'(63)) ? 6'd63 : w[5:0];
    endfunction

    // Segment classification: the first matching rule wins.
    always_comb
    begin
        if (seg_reg.tcp_flags[1] && !seg_reg.tcp_flags[4])
        begin
            kind = hst_pkg::K_OPEN;
        end
        else if (seg_reg.tcp_flags[1])
        begin
            kind = hst_pkg::K_SYNACK;
        end
        else if (seg_reg.tcp_flags[4])
        begin
            kind = hst_pkg::K_ACK;
        end
        else if (seg_reg.tcp_flags[0])
        begin
            kind = hst_pkg::K_FIN;
        end
        else
        begin
            kind = hst_pkg::K_OTHER;
        end
    end

    assign same_dir = (rdata_reg.resp_port == seg_reg.dest_port) &&
                      (rdata_reg.init_port == seg_reg.source_port);
    assign rev_dir  = (rdata_reg.resp_port == seg_reg.source_port) &&
                      (rdata_reg.init_port == seg_reg.dest_port);
    assign seq_inc  = rdata_reg.seq + 32'd1;

    always_comb
    begin
        case (kind)
            hst_pkg::K_SYNACK: kind_hit = rev_dir && (seg_reg.ack_value == seq_inc);
            hst_pkg::K_ACK:    kind_hit = same_dir && (seg_reg.seq_value == rdata_reg.seq);
            hst_pkg::K_FIN:    kind_hit = same_dir || rev_dir;
            default:           kind_hit = 1'b0;
        endcase
    end

    assign status.kind  = kind;
    assign status.full  = (count_reg == CAP);
    assign status.empty = (count_reg == '0);
    assign status.more  = (rd_addr_reg < count_reg);
    assign status.hit   = rd_pend_reg && kind_hit;

    // Entry update and counter bookkeeping for the committing segment.
    always_comb
    begin
        count_next = count_reg;
        unf_next   = unf_reg;
        irr_next   = irr_reg;
        hs_next    = hs_reg;
        we         = 1'b0;
        waddr      = rd_idx_reg;
        wdata      = rdata_reg;
        ev         = hst_pkg::EV_NONE;
        idx        = rd_idx_reg;
        if (cmd.commit)
        begin
            case (kind)
                hst_pkg::K_OPEN:
                begin
                    we               = 1'b1;
                    waddr            = count_reg[AW-1:0];
                    idx              = count_reg[AW-1:0];
                    wdata.init_port  = seg_reg.source_port;
                    wdata.resp_port  = seg_reg.dest_port;
                    wdata.seq        = seg_reg.seq_value;
                    wdata.peer_seq   = 32'd0;
                    wdata.stage      = hst_pkg::STAGE_OPEN;
                    wdata.close_mark = hst_pkg::CLOSE_NONE;
                    count_next       = count_reg + CW'(1);
                    unf_next         = unf_reg + CW'(1);
                    irr_next         = irr_reg + CW'(1);
                    ev               = hst_pkg::EV_OPENED;
                end
                hst_pkg::K_SYNACK:
                begin
                    we             = 1'b1;
                    wdata.seq      = seq_inc;
                    wdata.peer_seq = seg_reg.seq_value;
                    wdata.stage    = hst_pkg::STAGE_SYNACK;
                    if (rdata_reg.stage == hst_pkg::STAGE_DONE)
                    begin
                        unf_next = unf_reg + CW'(1);
                    end
                    ev = hst_pkg::EV_SYNACK;
                end
                hst_pkg::K_ACK:
                begin
                    we          = 1'b1;
                    wdata.stage = hst_pkg::STAGE_DONE;
                    if (rdata_reg.stage != hst_pkg::STAGE_DONE)
                    begin
                        unf_next = unf_reg - CW'(1);
                    end
                    if (hs_reg != 16'hFFFF)
                    begin
                        hs_next = hs_reg + 16'd1;
                    end
                    ev = hst_pkg::EV_DONE;
                end
                hst_pkg::K_FIN:
                begin
                    we = 1'b1;
                    if (same_dir)
                    begin
                        wdata.close_mark = hst_pkg::CLOSE_INIT;
                        if (rdata_reg.close_mark == hst_pkg::CLOSE_RESP)
                        begin
                            irr_next = irr_reg + CW'(1);
                        end
                        ev = hst_pkg::EV_FIN_INIT;
                    end
                    else
                    begin
                        wdata.close_mark = hst_pkg::CLOSE_RESP;
                        if (rdata_reg.close_mark != hst_pkg::CLOSE_RESP)
                        begin
                            irr_next = irr_reg - CW'(1);
                        end
                        ev = hst_pkg::EV_FIN_RESP;
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign idx_wide = (AW+5)'(idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            unf_reg     <= '0;
            irr_reg     <= '0;
            hs_reg      <= '0;
            rd_addr_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            unf_reg   <= unf_next;
            irr_reg   <= irr_next;
            hs_reg    <= hs_next;
            if (cmd.load)
            begin
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.start)
            begin
                rd_addr_reg <= CW'(1);
                rd_pend_reg <= 1'b1;
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + CW'(1);
                rd_pend_reg <= 1'b1;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.start)
        begin
            rdata_reg  <= mem[AW'(0)];
            rd_idx_reg <= AW'(0);
        end
        else if (cmd.issue)
        begin
            rdata_reg  <= mem[rd_addr_reg[AW-1:0]];
            rd_idx_reg <= rd_addr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seg_reg <= seg_in;
        end
        if (cmd.commit)
        begin
            res_reg.event_code            <= ev;
            res_reg.entry_index           <= idx_wide[4:0];
            res_reg.handshakes_done       <= hs_next;
            res_reg.sessions_open         <= sat6(count_next);
            res_reg.unfinished_count      <= sat6(unf_next);
            res_reg.irregular_close_count <= sat6(irr_next);
        end
        else if (cmd.finish_none)
        begin
            res_reg.event_code            <= (kind == hst_pkg::K_OPEN) ?
                                             hst_pkg::EV_FULL : hst_pkg::EV_NONE;
            res_reg.entry_index           <= 5'd0;
            res_reg.handshakes_done       <= hs_reg;
            res_reg.sessions_open         <= sat6(count_reg);
            res_reg.unfinished_count      <= sat6(unf_reg);
            res_reg.irregular_close_count <= sat6(irr_reg);
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/tcp_handshake_session_tracker.sv =====
// Top level of the TCP handshake session tracker.
`timescale 1ns / 1ps
// Usage
// The segment channel takes one TCP header per request: flags, both ports,
// sequence and acknowledgement numbers. The result channel returns exactly one
// request per segment, carrying an event code, the entry touched and four counts.
// Both channels complete a request when valid and ready are high at a clock edge.
// Sequencing: one segment is handled at a time. An opening SYN passes through
// the decode and write states before its result is presented; a full table or a
// segment that needs no lookup goes from decode straight to the result state.
// Segments that search the table walk the session memory one entry per cycle
// through its single registered read port and stop at the first match or after
// the last open session. The idle state comes round again before the next
// segment is taken.
// Reset clears the session count and all counters at once; table contents are
// only ever read below the session count, so the memory needs no clearing.
// When the receiver stalls, the result is held in its register with valid high
// and no new segment is accepted until the result has been taken.
`include "assert_macros.svh"

module tcp_handshake_session_tracker #(
    parameter int MAX_SESSIONS = hst_pkg::MAX_SESSIONS_DEF
) (
    input logic     clk,
    input logic     rst_n,
    hst_seg_if.sink   segment,
    hst_res_if.source result
);

    // Highest session count the six-bit result field can show.
    localparam logic [5:0] OPEN_CAP = (MAX_SESSIONS > 63) ? 6'd63 : 6'(MAX_SESSIONS);

    hst_pkg::seg_t       seg;
    hst_pkg::res_t       res;
    hst_pkg::dp_cmd_t    cmd;
    hst_pkg::dp_status_t status;

    // Gather the segment fields into one word for the datapath.
    assign seg.tcp_flags   = segment.tcp_flags;
    assign seg.source_port = segment.source_port;
    assign seg.dest_port   = segment.dest_port;
    assign seg.seq_value   = segment.seq_value;
    assign seg.ack_value   = segment.ack_value;

    // The controller owns both handshakes; the datapath owns the table.
    hst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (segment.valid),
        .in_ready  (segment.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hst_dp #(
        .MAX_SESSIONS (MAX_SESSIONS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .seg_in (seg),
        .cmd    (cmd),
        .status (status),
        .res    (res)
    );

    // The result register drives the outgoing channel directly.
    assign result.event_code            = res.event_code;
    assign result.entry_index           = res.entry_index;
    assign result.handshakes_done       = res.handshakes_done;
    assign result.sessions_open         = res.sessions_open;
    assign result.unfinished_count      = res.unfinished_count;
    assign result.irregular_close_count = res.irregular_close_count;

    // A new segment is never taken while a result is still on offer.
    `ASSERT_ALWAYS(a_one_in_flight, !(segment.ready && result.valid), "segment taken while result pending")

    // The session count shown can never exceed the table size.
    `ASSERT_IMPLIES(a_open_cap, result.valid, result.sessions_open <= OPEN_CAP, "session count above table size")

    // Unfinished and irregular entries are a subset of the open sessions.
    `ASSERT_IMPLIES(a_subset, result.valid, (result.unfinished_count <= result.sessions_open) && (result.irregular_close_count <= result.sessions_open), "entry count exceeds session count")

    // A refused SYN is only reported when the table really is full.
    `ASSERT_IMPLIES(a_full, result.valid && (result.event_code == hst_pkg::EV_FULL), result.sessions_open == OPEN_CAP, "table full reported below capacity")

    // Commands that move the table never fire while a result waits.
    `ASSERT_IMPLIES(a_quiet_out, result.valid, !(cmd.commit || cmd.start || cmd.issue), "table activity while result pending")

endmodule

// ===== dv/tcp_handshake_session_tracker_tb.sv =====
// Self-checking testbench for the TCP handshake session tracker.
`timescale 1ns / 1ps

module tcp_handshake_session_tracker_tb;

    // TCP flag bits as they appear in the flag byte of a segment.
    localparam logic [7:0] F_NONE  = 8'h00;
    localparam logic [7:0] F_FIN   = 8'h01;
    localparam logic [7:0] F_SYN   = 8'h02;
    localparam logic [7:0] F_RST   = 8'h04;
    localparam logic [7:0] F_ACK   = 8'h10;
    localparam logic [7:0] F_SPARE = 8'hE8;
    localparam logic [7:0] F_ALL   = 8'hFF;

    localparam int RANDOM_ITEMS = 1700;
    // Without idling for the last stretch, and with more SYNs near the end so the
    // table is sure to fill and overflow.
    localparam int CALM_TAIL    = 200;
    localparam int FILL_TAIL    = 300;
    localparam int DRAIN_CYCLES = 40;

    // A handful of recurring ports, so that several sessions share a port pair
    // and the first-match rule of the table search gets exercised.
    localparam logic [15:0] PORT_POOL [4] = '{16'd80, 16'd443, 16'd0, 16'hFFFF};

    // Mirror of the session table. It works out the result of every accepted
    // segment and checks the results in order of arrival.
    class session_table_checker;
        logic [15:0] init_port [hst_pkg::MAX_SESSIONS_DEF];
        logic [15:0] resp_port [hst_pkg::MAX_SESSIONS_DEF];
        logic [31:0] seq       [hst_pkg::MAX_SESSIONS_DEF];
        logic [31:0] peer_seq  [hst_pkg::MAX_SESSIONS_DEF];
        logic [1:0]  stage     [hst_pkg::MAX_SESSIONS_DEF];
        logic [1:0]  close_mark[hst_pkg::MAX_SESSIONS_DEF];
        int unsigned n_entries;
        logic [15:0] handshakes;
        int unsigned mismatches;
        hst_pkg::res_t outcome_q[$];

        function new();
            n_entries  = 0;
            handshakes = '0;
            mismatches = 0;
        endfunction

        function void note_segment(hst_pkg::seg_t s);
            hst_pkg::kind_t  kind;
            hst_pkg::event_t ev;
            hst_pkg::res_t   item;
            int unsigned     idx;
            int unsigned     unfinished;
            int unsigned     irregular;
            ev  = hst_pkg::EV_NONE;
            idx = 0;
            if ((s.tcp_flags & F_SYN) != 0 && (s.tcp_flags & F_ACK) == 0)
                kind = hst_pkg::K_OPEN;
            else if ((s.tcp_flags & F_SYN) != 0)
                kind = hst_pkg::K_SYNACK;
            else if ((s.tcp_flags & F_ACK) != 0)
                kind = hst_pkg::K_ACK;
            else if ((s.tcp_flags & F_FIN) != 0)
                kind = hst_pkg::K_FIN;
            else
                kind = hst_pkg::K_OTHER;

            case (kind)
                hst_pkg::K_OPEN:
                begin
                    if (n_entries >= hst_pkg::MAX_SESSIONS_DEF)
                        ev = hst_pkg::EV_FULL;
                    else
                    begin
                        init_port[n_entries]  = s.source_port;
                        resp_port[n_entries]  = s.dest_port;
                        seq[n_entries]        = s.seq_value;
                        peer_seq[n_entries]   = '0;
                        stage[n_entries]      = hst_pkg::STAGE_OPEN;
                        close_mark[n_entries] = hst_pkg::CLOSE_NONE;
                        idx = n_entries;
                        n_entries++;
                        ev = hst_pkg::EV_OPENED;
                    end
                end
                hst_pkg::K_SYNACK:
                begin
                    for (int i = 0; i < n_entries && ev == hst_pkg::EV_NONE; i++)
                    begin
                        if (resp_port[i] == s.source_port && init_port[i] == s.dest_port &&
                            s.ack_value == seq[i] + 32'd1)
                        begin
                            seq[i]      = seq[i] + 32'd1;
                            peer_seq[i] = s.seq_value;
                            stage[i]    = hst_pkg::STAGE_SYNACK;
                            ev  = hst_pkg::EV_SYNACK;
                            idx = i;
                        end
                    end
                end
                hst_pkg::K_ACK:
                begin
                    for (int i = 0; i < n_entries && ev == hst_pkg::EV_NONE; i++)
                    begin
                        if (resp_port[i] == s.dest_port && init_port[i] == s.source_port &&
                            s.seq_value == seq[i])
                        begin
                            stage[i] = hst_pkg::STAGE_DONE;
                            if (handshakes != 16'hFFFF)
                                handshakes++;
                            ev  = hst_pkg::EV_DONE;
                            idx = i;
                        end
                    end
                end
                hst_pkg::K_FIN:
                begin
                    for (int i = 0; i < n_entries && ev == hst_pkg::EV_NONE; i++)
                    begin
                        if (resp_port[i] == s.dest_port && init_port[i] == s.source_port)
                        begin
                            close_mark[i] = hst_pkg::CLOSE_INIT;
                            ev  = hst_pkg::EV_FIN_INIT;
                            idx = i;
                        end
                        else if (resp_port[i] == s.source_port &&
                                 init_port[i] == s.dest_port)
                        begin
                            close_mark[i] = hst_pkg::CLOSE_RESP;
                            ev  = hst_pkg::EV_FIN_RESP;
                            idx = i;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            unfinished = 0;
            irregular  = 0;
            for (int i = 0; i < n_entries; i++)
            begin
                if (stage[i] != hst_pkg::STAGE_DONE)
                    unfinished++;
                if (close_mark[i] != hst_pkg::CLOSE_RESP)
                    irregular++;
            end
            item = '{event_code:            ev,
                     entry_index:           5'(idx),
                     handshakes_done:       handshakes,
                     sessions_open:         6'(n_entries),
                     unfinished_count:      6'(unfinished),
                     irregular_close_count: 6'(irregular)};
            outcome_q.insert(outcome_q.size(), item);
        endfunction

        function void check_outcome(hst_pkg::res_t got);
            hst_pkg::res_t want;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result with none expected: ev=%0d idx=%0d hs=%0d open=%0d",
                         $time, got.event_code, got.entry_index, got.handshakes_done,
                         got.sessions_open);
                mismatches++;
                return;
            end
            want = outcome_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch: expected ev=%0d idx=%0d hs=%0d open=%0d unfin=%0d irr=%0d",
                         $time, want.event_code, want.entry_index, want.handshakes_done,
                         want.sessions_open, want.unfinished_count,
                         want.irregular_close_count);
                $display("%0t:           actual ev=%0d idx=%0d hs=%0d open=%0d unfin=%0d irr=%0d",
                         $time, got.event_code, got.entry_index, got.handshakes_done,
                         got.sessions_open, got.unfinished_count, got.irregular_close_count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;

    session_table_checker sb;

    hst_seg_if seg_ch ();
    hst_res_if res_ch ();

    tcp_handshake_session_tracker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .segment (seg_ch),
        .result  (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Hard stop in case the block hangs. The slowest correct run (a full table
    // walk, the longest sender gap and receiver stall on every request) stays
    // well under a fifth of this.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Both channels are watched at the rising edge. Inputs only ever move at the
    // falling edge, so what is seen here is the value that the block acted on.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_ch.valid && seg_ch.ready)
                sb.note_segment({seg_ch.tcp_flags, seg_ch.source_port, seg_ch.dest_port,
                                 seg_ch.seq_value, seg_ch.ack_value});
            if (res_ch.valid && res_ch.ready)
                sb.check_outcome({res_ch.event_code, res_ch.entry_index,
                                  res_ch.handshakes_done, res_ch.sessions_open,
                                  res_ch.unfinished_count, res_ch.irregular_close_count});
        end
    end

    // While idling is on, the receiver stalls now and then in bursts, so that the
    // held result register is exercised.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Offers one segment request, entered and left at a falling edge. Back-to-back
    // requests keep valid high, so valid is only lowered ahead of a real gap.
    task automatic push_segment(input logic [7:0]  flags,
                                input logic [15:0] sp,
                                input logic [15:0] dp,
                                input logic [31:0] sq,
                                input logic [31:0] ak);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(negedge clk);
        end
        seg_ch.valid       <= 1'b1;
        seg_ch.tcp_flags   <= flags;
        seg_ch.source_port <= sp;
        seg_ch.dest_port   <= dp;
        seg_ch.seq_value   <= sq;
        seg_ch.ack_value   <= ak;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0]  flags;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] swap;
        logic [31:0] sq;
        logic [31:0] ak;
        int unsigned roll;
        int unsigned pick;
        int unsigned e;
        int unsigned open_pct;

        sb = new();
        rst_n              = 1'b0;
        idle_on            = 1'b1;
        seg_ch.valid       = 1'b0;
        seg_ch.tcp_flags   = '0;
        seg_ch.source_port = '0;
        seg_ch.dest_port   = '0;
        seg_ch.seq_value   = '0;
        seg_ch.ack_value   = '0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With the table empty, a reset segment, a lone ACK and a
        // lone FIN all find nothing.
        push_segment(F_RST, 16'd1, 16'd2, 32'd0, 32'd0);
        push_segment(F_ACK, 16'd1, 16'd2, 32'd0, 32'd0);
        push_segment(F_FIN, 16'd1, 16'd2, 32'd0, 32'd0);
        // Session A at the port extremes with the top sequence number, so that the
        // stored number wraps to zero on its SYN+ACK. Session B has the same ports
        // the other way round and is opened by SYN+FIN, which still counts as an open.
        push_segment(F_SYN, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        push_segment(F_SYN | F_FIN, 16'hFFFF, 16'd0, 32'd0, 32'hFFFF_FFFF);
        push_segment(F_SYN | F_ACK, 16'hFFFF, 16'd0, 32'h1234_5678, 32'd0);
        // A SYN+ACK whose acknowledgement is one higher matches A again, as A's number moved on.
        push_segment(F_SYN | F_ACK, 16'hFFFF, 16'd0, 32'h1234_5678, 32'd1);
        // Two ACKs on A's ports with sequence zero; A's number has moved on, so neither matches.
        push_segment(F_ACK, 16'd0, 16'hFFFF, 32'd0, 32'h1234_5679);
        push_segment(F_ACK, 16'd0, 16'hFFFF, 32'd0, 32'h1234_5679);
        // FIN together with ACK is taken as a pure ACK; it completes B straight
        // from stage one.
        push_segment(F_ACK | F_FIN, 16'hFFFF, 16'd0, 32'd0, 32'd0);
        // Session C with every flag bit but ACK set, then its SYN+ACK with all bits set.
        push_segment(F_ALL & ~F_ACK, 16'h1234, 16'h0050, 32'h8000_0000, 32'd0);
        push_segment(F_ALL, 16'h0050, 16'h1234, 32'hFFFF_FFFF, 32'h8000_0001);
        // Closes of C from the initiator and then from the responder.
        push_segment(F_FIN, 16'h1234, 16'h0050, 32'd0, 32'd0);
        push_segment(F_FIN, 16'h0050, 16'h1234, 32'd0, 32'd0);
        // Both of these ports match A and B; the first entry, A, takes the close
        // each time, once the same way round and once reversed.
        push_segment(F_FIN, 16'd0, 16'hFFFF, 32'd0, 32'd0);
        push_segment(F_FIN, 16'hFFFF, 16'd0, 32'd0, 32'd0);
        // Segments that are none of the classes, and a FIN with no matching ports.
        push_segment(F_FIN | F_RST, 16'd7, 16'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_segment(F_NONE, 16'h1234, 16'h0050, 32'h8000_0001, 32'd0);
        push_segment(F_SPARE, 16'h1234, 16'h0050, 32'h8000_0001, 32'd0);
        // A pure ACK on C's ports with a sequence number one off matches nothing.
        push_segment(F_ACK, 16'h1234, 16'h0050, 32'h8000_0002, 32'd0);
        // Session D reuses C's ports; its SYN+ACK skips C, whose sequence differs.
        push_segment(F_SYN, 16'h1234, 16'h0050, 32'd5, 32'd0);
        push_segment(F_SYN | F_ACK, 16'h0050, 16'h1234, 32'd77, 32'd6);
        push_segment(F_ACK, 16'h1234, 16'h0050, 32'd6, 32'd78);

        // Random part. Most requests are well-formed handshake steps aimed at a live
        // session, the rest broken steps and noise. Opens are kept rare, since the
        // table never empties, and pick up near the end so that it overflows.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (k >= RANDOM_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            open_pct = (k >= RANDOM_ITEMS - FILL_TAIL) ? 12 : 3;

            flags = 8'($urandom) & (F_SPARE | F_RST);
            sp    = 16'($urandom);
            dp    = 16'($urandom);
            sq    = $urandom;
            ak    = $urandom;
            roll  = $urandom_range(0, 99);

            if (roll < open_pct)
            begin
                flags |= F_SYN;
                if ($urandom_range(0, 1) == 0)
                    flags |= F_FIN;
                if ($urandom_range(0, 1) == 0)
                begin
                    sp = PORT_POOL[$urandom_range(0, 3)];
                    dp = PORT_POOL[$urandom_range(0, 3)];
                end
                if ($urandom_range(0, 7) == 0)
                    sq = 32'hFFFF_FFFF;
            end
            else if (sb.n_entries > 0 && roll < 88)
            begin
                e    = $urandom_range(0, sb.n_entries - 1);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    // Responder's SYN+ACK.
                    flags |= F_SYN | F_ACK;
                    sp = sb.resp_port[e];
                    dp = sb.init_port[e];
                    ak = sb.seq[e] + 32'd1;
                end
                else if (pick < 60)
                begin
                    // Initiator's final ACK, sometimes carrying FIN as well.
                    flags |= F_ACK;
                    if ($urandom_range(0, 3) == 0)
                        flags |= F_FIN;
                    sp = sb.init_port[e];
                    dp = sb.resp_port[e];
                    sq = sb.seq[e];
                    ak = sb.peer_seq[e] + 32'd1;
                end
                else if (pick < 78)
                begin
                    // Close from either side.
                    flags |= F_FIN;
                    sp = sb.init_port[e];
                    dp = sb.resp_port[e];
                    if ($urandom_range(0, 1) == 0)
                    begin
                        swap = sp;
                        sp   = dp;
                        dp   = swap;
                    end
                end
                else
                begin
                    // A nearly right step with one field spoiled.
                    flags |= F_ACK;
                    if ($urandom_range(0, 1) == 0)
                        flags |= F_SYN;
                    sp = sb.init_port[e];
                    dp = sb.resp_port[e];
                    sq = sb.seq[e];
                    ak = sb.seq[e] + 32'd1;
                    case ($urandom_range(0, 2))
                        0:       sp = sp ^ (16'd1 << $urandom_range(0, 15));
                        1:       sq = sq + 32'd1;
                        default: ak = ak - 32'd1;
                    endcase
                end
            end
            else
                flags = 8'($urandom);

            push_segment(flags, sp, dp, sq, ak);
        end
        seg_ch.valid <= 1'b0;

        // Let the last results drain, then give the block a little longer in case
        // it produces something it should not.
        while (sb.outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.outcome_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hst_pkg.sv
hw/rtl/hst_if.sv
hw/rtl/hst_ctrl.sv
hw/rtl/hst_dp.sv
hw/rtl/tcp_handshake_session_tracker.sv
dv/tcp_handshake_session_tracker_tb.sv
